FILE: hdl/perception_msg_trigger_top_macros.svh
// assertion macros shared by the checker
`ifndef PERCEPTION_MSG_TRIGGER_TOP_MACROS_SVH
`define PERCEPTION_MSG_TRIGGER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define PMT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("pmt check failed");

// next-cycle implication, checked outside reset
`define PMT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("pmt check failed");

`endif

FILE: hdl/pmt_pkg.sv
package pmt_pkg;

  localparam int unsigned IN_TDATA_W  = 144;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam int unsigned SENSOR_INFO_PERIOD_DEFAULT = 1000;

  localparam logic [11:0] HEADING_FULL = 12'd3600;
  localparam logic [11:0] HEADING_HALF = 12'd1800;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_INTERVAL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING_THR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POSITION_THR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_THR      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CONGESTION_EN  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_RATE     = 3'd7;

  // reset values
  localparam logic [15:0] MIN_INTERVAL_RST  = 16'd100;
  localparam logic [15:0] MAX_INTERVAL_RST  = 16'd1000;
  localparam logic [15:0] SLOW_INTERVAL_RST = 16'd1000;
  localparam logic [11:0] HEADING_THR_RST   = 12'd40;
  localparam logic [15:0] POSITION_THR_RST  = 16'd400;
  localparam logic [15:0] SPEED_THR_RST     = 16'd50;
  localparam logic [31:0] POSITION_THR_SQ_RST = 32'd160000;

  typedef enum logic [1:0] {
    REASON_NONE    = 2'd0,
    REASON_FIXED   = 2'd1,
    REASON_DYNAMIC = 2'd2,
    REASON_SLOW    = 2'd3
  } reason_e;

  typedef struct packed {
    logic [15:0] min_interval;
    logic [15:0] max_interval;
    logic [15:0] slow_interval;
    logic [11:0] heading_threshold;
    logic [15:0] position_threshold;
    logic [15:0] speed_threshold;
    logic        congestion_enable;
    logic        fixed_rate;
  } cfg_t;

  typedef struct packed {
    logic        [31:0] time_now;
    logic        [11:0] heading;
    logic signed [30:0] pos_x;
    logic signed [30:0] pos_y;
    logic signed [15:0] speed;
    logic        [15:0] congestion_delay;
  } item_t;

  typedef struct packed {
    logic        [31:0] last_time;
    logic        [11:0] last_heading;
    logic signed [30:0] last_x;
    logic signed [30:0] last_y;
    logic signed [15:0] last_speed;
    logic        [31:0] last_sensor_time;
    logic               sensor_pending;
  } state_t;

  typedef struct packed {
    logic    send;
    reason_e reason;
    logic    with_sensor_info;
  } res_t;

  function automatic logic [11:0] wrap_heading(input logic [11:0] h);
    return (h >= HEADING_FULL) ? (h - HEADING_FULL) : h;
  endfunction

endpackage

FILE: hdl/pmt_decide.sv
module pmt_decide #(
  parameter int unsigned SENSOR_INFO_PERIOD = pmt_pkg::SENSOR_INFO_PERIOD_DEFAULT
) (
  input  pmt_pkg::item_t  item_i,
  input  pmt_pkg::cfg_t   cfg_i,
  input  logic [31:0]     pos_thr_sq_i,
  input  pmt_pkg::state_t state_i,
  output pmt_pkg::res_t   res_o
);

  logic [31:0] elapsed;
  logic [31:0] sensor_elapsed;
  logic [15:0] gate_lo;
  logic [15:0] gate;
  logic        gate_open;

  logic [11:0] hd_a, hd_b, hd_diff, hd_circ;
  logic        heading_moved;

  logic signed [31:0] dx, dy;
  logic [31:0] adx, ady;
  logic [63:0] dx_sq, dy_sq, dist_sq;
  logic        position_moved;

  logic signed [16:0] ds;
  logic [16:0] ads;
  logic        speed_moved;

  pmt_pkg::reason_e reason;

  assign elapsed        = item_i.time_now - state_i.last_time;
  assign sensor_elapsed = item_i.time_now - state_i.last_sensor_time;

  // clamp of the congestion delay, swapped bounds give max; min_interval when congestion is disabled
  assign gate_lo = (item_i.congestion_delay > cfg_i.min_interval) ?
                   item_i.congestion_delay : cfg_i.min_interval;
  assign gate    = !cfg_i.congestion_enable ? cfg_i.min_interval :
                   ((gate_lo < cfg_i.max_interval) ? gate_lo : cfg_i.max_interval);
  assign gate_open = elapsed >= {16'd0, gate};

  // heading difference around the circle
  assign hd_a    = pmt_pkg::wrap_heading(item_i.heading);
  assign hd_b    = pmt_pkg::wrap_heading(state_i.last_heading);
  assign hd_diff = (hd_a > hd_b) ? (hd_a - hd_b) : (hd_b - hd_a);
  assign hd_circ = (hd_diff > pmt_pkg::HEADING_HALF) ?
                   (pmt_pkg::HEADING_FULL - hd_diff) : hd_diff;
  assign heading_moved = hd_circ > cfg_i.heading_threshold;

  // squared distance, exact
  assign dx  = {item_i.pos_x[30], item_i.pos_x} - {state_i.last_x[30], state_i.last_x};
  assign dy  = {item_i.pos_y[30], item_i.pos_y} - {state_i.last_y[30], state_i.last_y};
  assign adx = dx[31] ? 32'(-dx) : 32'(dx);
  assign ady = dy[31] ? 32'(-dy) : 32'(dy);
  assign dx_sq   = 64'(adx) * 64'(adx);
  assign dy_sq   = 64'(ady) * 64'(ady);
  assign dist_sq = dx_sq + dy_sq;
  assign position_moved = dist_sq > {32'd0, pos_thr_sq_i};

  assign ds  = {item_i.speed[15], item_i.speed} - {state_i.last_speed[15], state_i.last_speed};
  assign ads = ds[16] ? 17'(-ds) : 17'(ds);
  assign speed_moved = ads > {1'b0, cfg_i.speed_threshold};

  always_comb begin
    reason = pmt_pkg::REASON_NONE;
    if (gate_open) begin
      if (cfg_i.fixed_rate) begin
        reason = pmt_pkg::REASON_FIXED;
      end else if (heading_moved || position_moved || speed_moved) begin
        reason = pmt_pkg::REASON_DYNAMIC;
      end else if (elapsed >= {16'd0, cfg_i.slow_interval}) begin
        reason = pmt_pkg::REASON_SLOW;
      end
    end
  end

  assign res_o.send   = (reason != pmt_pkg::REASON_NONE);
  assign res_o.reason = reason;
  assign res_o.with_sensor_info = res_o.send &&
    (state_i.sensor_pending || (sensor_elapsed >= 32'(SENSOR_INFO_PERIOD)));

endmodule

FILE: hdl/perception_msg_trigger_top.sv
// channel   | dir | signals                                | tdata fields, lowest bit up
// s_axis    | in  | s_axis_tvalid, s_axis_tready, tdata    | time_now, heading, pos_x, pos_y,
//           |     |                                        | speed, congestion_delay
// m_axis    | out | m_axis_tvalid, m_axis_tready, tdata    | send, send_reason, with_sensor_info
// cfg       | in  | cfg_we_i, cfg_idx_i, cfg_data_i        | one register per write
//
// one tick accepted per cycle while the input is not stalled; it is registered in the input
// register and its result in the output register; the decision is combinational logic from
// the input register, with the two 32x32 squares of the position check as the longest path
// a stalled result holds in the output register while the next tick waits in the
// input register; the input stalls only when both are full
// asynchronous active-low reset loads register defaults and clears the stored state
module perception_msg_trigger_top #(
  parameter int unsigned SENSOR_INFO_PERIOD = pmt_pkg::SENSOR_INFO_PERIOD_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // time_now[31:0], heading[43:32], pos_x[74:44], pos_y[105:75], speed[121:106],
  // congestion_delay[137:122], zero fill
  input  logic [pmt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // send[0], send_reason[2:1], with_sensor_info[3], zero fill
  output logic [pmt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                               cfg_we_i,
  input  logic [pmt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pmt_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  pmt_pkg::cfg_t   cfg_q;
  pmt_pkg::state_t state_q;
  pmt_pkg::item_t  item_q, item_d;
  pmt_pkg::res_t   res;
  logic [31:0]     pos_thr_sq_q;
  logic            in_valid_q;
  logic            out_valid_q;
  logic [pmt_pkg::OUT_TDATA_W-1:0] out_data_q, out_data_d;
  logic            advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign item_d.time_now         = s_axis_tdata[31:0];
  assign item_d.heading          = s_axis_tdata[43:32];
  assign item_d.pos_x            = s_axis_tdata[74:44];
  assign item_d.pos_y            = s_axis_tdata[105:75];
  assign item_d.speed            = s_axis_tdata[121:106];
  assign item_d.congestion_delay = s_axis_tdata[137:122];

  assign out_data_d = {4'd0, res.with_sensor_info, res.reason, res.send};

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_interval       <= pmt_pkg::MIN_INTERVAL_RST;
      cfg_q.max_interval       <= pmt_pkg::MAX_INTERVAL_RST;
      cfg_q.slow_interval      <= pmt_pkg::SLOW_INTERVAL_RST;
      cfg_q.heading_threshold  <= pmt_pkg::HEADING_THR_RST;
      cfg_q.position_threshold <= pmt_pkg::POSITION_THR_RST;
      cfg_q.speed_threshold    <= pmt_pkg::SPEED_THR_RST;
      cfg_q.congestion_enable  <= 1'b1;
      cfg_q.fixed_rate         <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pmt_pkg::REG_MIN_INTERVAL:  cfg_q.min_interval       <= cfg_data_i;
        pmt_pkg::REG_MAX_INTERVAL:  cfg_q.max_interval       <= cfg_data_i;
        pmt_pkg::REG_SLOW_INTERVAL: cfg_q.slow_interval      <= cfg_data_i;
        pmt_pkg::REG_HEADING_THR:   cfg_q.heading_threshold  <= cfg_data_i[11:0];
        pmt_pkg::REG_POSITION_THR:  cfg_q.position_threshold <= cfg_data_i;
        pmt_pkg::REG_SPEED_THR:     cfg_q.speed_threshold    <= cfg_data_i;
        pmt_pkg::REG_CONGESTION_EN: cfg_q.congestion_enable  <= cfg_data_i[0];
        pmt_pkg::REG_FIXED_RATE:    cfg_q.fixed_rate         <= cfg_data_i[0];
      endcase
    end
  end

  // squared position threshold, registered from the stored position threshold
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_thr_sq_q <= pmt_pkg::POSITION_THR_SQ_RST;
    end else begin
      pos_thr_sq_q <= 32'(cfg_q.position_threshold) * 32'(cfg_q.position_threshold);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q <= item_d;
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  // vehicle state of the last sent message
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.last_time        <= '0;
      state_q.last_heading     <= '0;
      state_q.last_x           <= '0;
      state_q.last_y           <= '0;
      state_q.last_speed       <= '0;
      state_q.last_sensor_time <= '0;
      state_q.sensor_pending   <= 1'b1;
    end else if (advance && res.send) begin
      state_q.last_time    <= item_q.time_now;
      state_q.last_heading <= item_q.heading;
      state_q.last_x       <= item_q.pos_x;
      state_q.last_y       <= item_q.pos_y;
      state_q.last_speed   <= item_q.speed;
      if (res.with_sensor_info) begin
        state_q.last_sensor_time <= item_q.time_now;
        state_q.sensor_pending   <= 1'b0;
      end
    end
  end

  pmt_decide #(
    .SENSOR_INFO_PERIOD(SENSOR_INFO_PERIOD)
  ) u_decide (
    .item_i       (item_q),
    .cfg_i        (cfg_q),
    .pos_thr_sq_i (pos_thr_sq_q),
    .state_i      (state_q),
    .res_o        (res)
  );

endmodule

FILE: hdl/pmt_checker.sv
`include "perception_msg_trigger_top_macros.svh"

module pmt_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [pmt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // a waiting result holds still
  `PMT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                  m_axis_tvalid && $stable(m_axis_tdata))

  // no send means every other field is clear
  `PMT_ASSERT_IMP(a_nosend_clear, clk_i, rst_ni, m_axis_tvalid && !m_axis_tdata[0],
                  m_axis_tdata[3:1] == 3'd0)

  // a send always carries a reason
  `PMT_ASSERT_IMP(a_send_reason, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[0],
                  m_axis_tdata[2:1] != 2'(pmt_pkg::REASON_NONE))

  // input back-pressure only while a result waits
  `PMT_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, !s_axis_tready,
                  m_axis_tvalid && !m_axis_tready)

endmodule

bind perception_msg_trigger_top pmt_checker u_pmt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
